// ===== sv/ltsg_pkg.sv =====
// shared types, constants and codes for the loop track speed governor
package ltsg_pkg;

  localparam int FRACTION_BITS = 10;
  localparam int STATION_COUNT = 19;
  localparam int TABLE_LEN     = 19;
  localparam int ROUND_HALF    = 1 << (FRACTION_BITS - 1);

  typedef logic [16:0] pos_t;
  typedef logic [12:0] speed_t;
  typedef logic [4:0]  station_t;
  typedef logic [15:0] timer_t;

  // loop geometry, 1/1024 m
  localparam pos_t   LOOP_LEN        = 17'd101865;
  localparam pos_t   ARRIVE_TOL      = 17'd563;
  localparam pos_t   STRAIGHT1_END   = 17'd40960;
  localparam pos_t   STRAIGHT2_BEGIN = 17'd50709;
  localparam pos_t   STRAIGHT2_END   = 17'd91669;
  localparam speed_t SPEED_MAX       = 13'd8191;
  localparam station_t DEFAULT_STATION = 5'd15;

  // station positions, 1/1024 m
  localparam pos_t STATION_POS [TABLE_LEN] = '{
    17'd0,     17'd87983, 17'd85525, 17'd81839, 17'd79381, 17'd75695, 17'd73237,
    17'd69551, 17'd67093, 17'd63407, 17'd60949, 17'd57263, 17'd54805,
    17'd32768, 17'd29696, 17'd26624, 17'd14336, 17'd11264, 17'd8192
  };

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_ACCEL   = 2'd1,
    MODE_DECEL   = 2'd2
  } mode_t;

  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_ASSIGN = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_ACCEL          = 3'd0,
    REG_CURVE_LIMIT    = 3'd1,
    REG_STRAIGHT_LIMIT = 3'd2,
    REG_BODY_LENGTH    = 3'd3,
    REG_SAFETY_MARGIN  = 3'd4,
    REG_LOAD_TIME      = 3'd5,
    REG_TICK_TIME      = 3'd6,
    REG_RETURN_STATION = 3'd7
  } reg_idx_t;

  typedef struct packed {
    op_t      opcode;
    pos_t     lead_position;
    station_t new_station;
  } ltsg_in_t;

  typedef struct packed {
    pos_t     position_out;
    speed_t   speed_out;
    mode_t    motion_out;
    logic     dwelling;
    station_t station_out;
  } ltsg_out_t;

  typedef struct packed {
    reg_idx_t    addr;
    logic [15:0] wdata;
  } ltsg_cfg_t;

  // register file contents plus values derived from them at write time
  typedef struct packed {
    speed_t      accel;
    speed_t      curve_speed_limit;
    speed_t      straight_speed_limit;
    speed_t      body_length;
    speed_t      safety_margin;
    timer_t      load_time;
    logic [9:0]  tick_time;
    station_t    return_station;
    speed_t      dv;
    logic [25:0] vc2;
  } ltsg_regs_t;

  typedef struct packed {
    pos_t     position;
    speed_t   speed;
    mode_t    mode;
    timer_t   dwell_timer;
    station_t target;
  } ltsg_state_t;

  function automatic logic station_ok(station_t s);
    return (s >= 5'd1) && (32'(s) < STATION_COUNT) && (32'(s) < TABLE_LEN);
  endfunction

endpackage

// ===== sv/ltsg_stream_if.sv =====
// valid/ready channel carrying one payload type
interface ltsg_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/ltsg_cfg_regs.sv =====
// configuration registers with the speed step and curve speed square kept alongside
module ltsg_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  ltsg_stream_if.sink         cfg,
  output ltsg_pkg::ltsg_regs_t regs
);
  import ltsg_pkg::*;

  localparam ltsg_regs_t REGS_RESET = '{
    accel:                13'd512,
    curve_speed_limit:    13'd683,
    straight_speed_limit: 13'd2731,
    body_length:          13'd2048,
    safety_margin:        13'd205,
    load_time:            16'd7680,
    tick_time:            10'd10,
    return_station:       DEFAULT_STATION,
    dv:                   13'd5,
    vc2:                  26'd466489
  };

  logic        wr;
  speed_t      mul_a;
  logic [9:0]  mul_t;
  logic [22:0] dv_prod;
  logic [23:0] dv_round;
  speed_t      curve_new;
  logic [25:0] vc2_prod;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid && cfg.ready;

  // operands follow the write so the derived values land with the register
  always_comb begin
    mul_a     = regs.accel;
    mul_t     = regs.tick_time;
    curve_new = cfg.data.wdata[12:0];
    if (wr && cfg.data.addr == REG_ACCEL) begin
      mul_a = cfg.data.wdata[12:0];
    end
    if (wr && cfg.data.addr == REG_TICK_TIME) begin
      mul_t = cfg.data.wdata[9:0];
    end
  end

  assign dv_prod  = {10'd0, mul_a} * {13'd0, mul_t};
  assign dv_round = {1'b0, dv_prod} + 24'(ROUND_HALF);
  assign vc2_prod = {13'd0, curve_new} * {13'd0, curve_new};

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= REGS_RESET;
    end else if (wr) begin
      unique case (cfg.data.addr)
        REG_ACCEL: begin
          regs.accel <= cfg.data.wdata[12:0];
          regs.dv    <= dv_round[FRACTION_BITS+12:FRACTION_BITS];
        end
        REG_CURVE_LIMIT: begin
          regs.curve_speed_limit <= cfg.data.wdata[12:0];
          regs.vc2               <= vc2_prod;
        end
        REG_STRAIGHT_LIMIT: regs.straight_speed_limit <= cfg.data.wdata[12:0];
        REG_BODY_LENGTH:    regs.body_length <= cfg.data.wdata[12:0];
        REG_SAFETY_MARGIN:  regs.safety_margin <= cfg.data.wdata[12:0];
        REG_LOAD_TIME:      regs.load_time <= cfg.data.wdata;
        REG_TICK_TIME: begin
          regs.tick_time <= cfg.data.wdata[9:0];
          regs.dv        <= dv_round[FRACTION_BITS+12:FRACTION_BITS];
        end
        REG_RETURN_STATION: regs.return_station <= cfg.data.wdata[4:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/ltsg_step.sv =====
// one governor step: gap and target distance, dwell, braking decision, speed and position
module ltsg_step (
  input  ltsg_pkg::ltsg_regs_t  regs,
  input  ltsg_pkg::ltsg_state_t st,
  input  ltsg_pkg::ltsg_in_t    item,
  output ltsg_pkg::ltsg_state_t st_next,
  output ltsg_pkg::ltsg_out_t   res
);
  import ltsg_pkg::*;

  function automatic pos_t fwd_dist(pos_t from, pos_t to);
    return (to >= from) ? (to - from) : (to + LOOP_LEN - from);
  endfunction

  function automatic pos_t station_pos(station_t s);
    return station_ok(s) ? STATION_POS[s] : '0;
  endfunction

  function automatic speed_t scale_time(logic [22:0] p);
    logic [23:0] r;
    r = {1'b0, p} + 24'(ROUND_HALF);
    return r[FRACTION_BITS+12:FRACTION_BITS];
  endfunction

  pos_t        pos, lead, gap, tdist_cur, tdist_ret, tdist, dcurve, np;
  logic        tgt_ok, ret_ok, arrive, done, hold, switch_tgt;
  logic [16:0] t_sum;
  timer_t      t_sat;
  station_t    target_new;
  logic [25:0] v2;
  logic [13:0] a2;
  logic signed [18:0] gd;
  logic signed [33:0] gap_prod;
  logic [30:0] tgt_prod, curve_prod;
  logic signed [26:0] v_excess;
  logic        on_s1, on_s2, straight;
  logic        c_gap, c_tgt, c_curve, c_slow, brake;
  logic [13:0] up_sum;
  speed_t      up, dn, cand, lim, speed_fin, step;
  logic        stop, over;
  logic [22:0] up_prod, dn_prod, lim_prod;
  logic [17:0] np_sum;
  mode_t       mode_fin;

  assign pos  = st.position;
  assign lead = (item.lead_position >= LOOP_LEN) ? item.lead_position - LOOP_LEN
                                                 : item.lead_position;
  assign gap  = fwd_dist(pos, lead);

  // target distance for the current and the return station side by side
  assign tgt_ok    = station_ok(st.target);
  assign ret_ok    = station_ok(regs.return_station);
  assign tdist_cur = fwd_dist(pos, station_pos(st.target));
  assign tdist_ret = fwd_dist(pos, station_pos(regs.return_station));

  assign arrive     = (st.mode == MODE_STOPPED) && tgt_ok && (tdist_cur < ARRIVE_TOL);
  assign t_sum      = {1'b0, st.dwell_timer} + {7'd0, regs.tick_time};
  assign t_sat      = t_sum[16] ? 16'hFFFF : t_sum[15:0];
  assign done       = t_sat >= regs.load_time;
  assign hold       = arrive && !done;
  assign switch_tgt = arrive && done && ret_ok;
  assign target_new = switch_tgt ? regs.return_station : st.target;
  assign tdist      = switch_tgt ? tdist_ret : tdist_cur;

  // braking tests as v*v against 2*a*d
  assign v2 = {13'd0, st.speed} * {13'd0, st.speed};
  assign a2 = {regs.accel, 1'b0};
  assign gd = $signed({2'b00, gap}) - $signed({6'd0, regs.body_length})
              - $signed({6'd0, regs.safety_margin});
  assign gap_prod = $signed({1'b0, a2}) * gd;
  assign c_gap    = $signed({8'd0, v2}) >= gap_prod;

  assign tgt_prod = {17'd0, a2} * {14'd0, tdist};
  assign c_tgt    = tgt_ok && ({5'd0, v2} >= tgt_prod);

  assign on_s1    = pos <= STRAIGHT1_END;
  assign on_s2    = (pos >= STRAIGHT2_BEGIN) && (pos <= STRAIGHT2_END);
  assign straight = on_s1 || on_s2;
  // both straights end at a curve, one multiplier serves either
  assign dcurve     = on_s1 ? (STRAIGHT1_END - pos) : (STRAIGHT2_END - pos);
  assign curve_prod = {17'd0, a2} * {14'd0, dcurve};
  assign v_excess   = $signed({1'b0, v2}) - $signed({1'b0, regs.vc2});
  assign c_curve    = straight &&
                      ($signed({1'b0, curve_prod}) <= 32'(v_excess));
  assign c_slow     = !straight && (st.speed > regs.curve_speed_limit);

  assign brake = c_gap || c_tgt || c_curve || c_slow;

  // speed candidates and their travel, multiplied in parallel
  assign up_sum    = {1'b0, st.speed} + {1'b0, regs.dv};
  assign up        = up_sum[13] ? SPEED_MAX : up_sum[12:0];
  assign stop      = st.speed <= regs.dv;
  assign dn        = stop ? '0 : st.speed - regs.dv;
  assign cand      = brake ? dn : up;
  assign lim       = straight ? regs.straight_speed_limit : regs.curve_speed_limit;
  assign over      = cand > lim;
  assign speed_fin = over ? lim : cand;
  assign mode_fin  = brake ? (stop ? MODE_STOPPED : MODE_DECEL) : MODE_ACCEL;

  assign up_prod  = {10'd0, up} * {13'd0, regs.tick_time};
  assign dn_prod  = {10'd0, dn} * {13'd0, regs.tick_time};
  assign lim_prod = {10'd0, lim} * {13'd0, regs.tick_time};
  assign step     = over ? scale_time(lim_prod)
                         : (brake ? scale_time(dn_prod) : scale_time(up_prod));

  assign np_sum = {1'b0, pos} + {5'd0, step};
  assign np     = (np_sum >= {1'b0, LOOP_LEN}) ? 17'(np_sum - {1'b0, LOOP_LEN})
                                               : np_sum[16:0];

  always_comb begin
    st_next = st;
    unique case (item.opcode)
      OP_ASSIGN: begin
        if (station_ok(item.new_station)) begin
          st_next.target = item.new_station;
          st_next.mode   = MODE_ACCEL;
        end
      end
      OP_TICK: begin
        if (hold) begin
          st_next.speed       = '0;
          st_next.dwell_timer = t_sat;
        end else begin
          st_next.position    = np;
          st_next.speed       = speed_fin;
          st_next.mode        = mode_fin;
          st_next.target      = target_new;
          st_next.dwell_timer = arrive ? '0 : st.dwell_timer;
        end
      end
      default: ;
    endcase
  end

  assign res.position_out = st_next.position;
  assign res.speed_out    = st_next.speed;
  assign res.motion_out   = st_next.mode;
  assign res.dwelling     = (item.opcode == OP_TICK) && hold;
  assign res.station_out  = st_next.target;

endmodule

// ===== sv/ltsg_out_buf.sv =====
// two-entry result queue driving the result channel
module ltsg_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ltsg_pkg::ltsg_out_t push_data,
  output logic                room,
  ltsg_stream_if.source       res
);
  import ltsg_pkg::*;

  ltsg_out_t  mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign res.valid = count != 2'd0;
  assign res.data  = mem[rd_ptr];
  assign pop       = res.valid && res.ready;
  assign room      = (count != 2'd2) || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== sv/loop_track_vehicle_speed_governor_core.sv =====
// top level of the loop track vehicle speed governor
// a transaction accepted into the input register has its result written to the result queue
// once the queue has room, and the result then shows on res; throughput: one transaction
// per cycle while the queue has room, set by the single step from input to result register
// the two-entry result queue keeps input accepted while one result waits
// reset (rst, synchronous): vehicle state and queue cleared, registers to their defaults
module loop_track_vehicle_speed_governor_core (
  input  logic          clk,
  input  logic          rst,
  ltsg_stream_if.sink   cmd,
  ltsg_stream_if.source res,
  ltsg_stream_if.sink   cfg
);
  import ltsg_pkg::*;

  localparam ltsg_state_t STATE_RESET = '{
    position:    '0,
    speed:       '0,
    mode:        MODE_STOPPED,
    dwell_timer: '0,
    target:      DEFAULT_STATION
  };

  ltsg_regs_t  regs;
  ltsg_state_t st, st_next;
  ltsg_in_t    in_item;
  logic        in_valid;
  ltsg_out_t   step_res;
  logic        room, fire;

  assign fire      = in_valid && room;
  assign cmd.ready = !in_valid || fire;

  ltsg_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ltsg_step u_step (
    .regs    (regs),
    .st      (st),
    .item    (in_item),
    .st_next (st_next),
    .res     (step_res)
  );

  ltsg_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (step_res),
    .room      (room),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      st       <= STATE_RESET;
    end else begin
      if (cmd.valid && cmd.ready) begin
        in_valid <= 1'b1;
      end else if (fire) begin
        in_valid <= 1'b0;
      end
      if (fire) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_item <= cmd.data;
    end
  end

endmodule

// ===== sv/ltsg_checker.sv =====
// port-level checks on the governor top level, bound to it
module ltsg_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [16:0] res_position,
  input logic [12:0] res_speed,
  input logic [1:0]  res_motion,
  input logic        res_dwelling
);
  import ltsg_pkg::*;

  // a waiting result is not withdrawn
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result withdrawn before taken");

  // a new result only follows an accepted transaction
  a_res_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(cmd_valid && cmd_ready, 2))
    else $error("result without a preceding transaction");

  // dwelling holds the vehicle stopped
  a_dwell_stopped: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_dwelling |-> (res_motion == MODE_STOPPED) && (res_speed == 13'd0))
    else $error("dwelling while moving");

  // stopped mode always carries zero speed
  a_stop_speed: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_motion == MODE_STOPPED) |-> res_speed == 13'd0)
    else $error("stopped with nonzero speed");

  // position stays on the loop
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_position < LOOP_LEN)
    else $error("position beyond loop length");

endmodule

bind loop_track_vehicle_speed_governor_core ltsg_checker u_ltsg_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_position (res.data.position_out),
  .res_speed    (res.data.speed_out),
  .res_motion   (res.data.motion_out),
  .res_dwelling (res.data.dwelling)
);
